// ===== hdl/aabbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// aabbfc_pkg
// shared constants and types for the aabb frustum cull test core
// ----------------------------------------------------------------------------
package aabbfc_pkg;

    // planes and coordinate format
    localparam int PLANE_COUNT   = 4;
    localparam int PLANE_REGS    = 4;
    localparam int ACTIVE_PLANES = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;
    localparam int AXES          = 3;
    localparam int INPUT_BITS    = 20;
    localparam int COORD_BITS    = 20;
    localparam int NORMAL_BITS   = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int OFFSET_SHIFT  = 3;

    // product and plane-sum widths, all exact
    localparam int PROD_BITS = NORMAL_BITS + COORD_BITS;
    localparam int EVAL_BITS = ((PROD_BITS + 2 > OFFSET_BITS + OFFSET_SHIFT) ?
                                (PROD_BITS + 2) : (OFFSET_BITS + OFFSET_SHIFT)) + 1;

    // configuration port
    localparam int VIEW_BOX_BITS   = 60;
    localparam int NORMAL_REG_BITS = 48;
    localparam int OFFSET_REG_BITS = 64;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VIEW_BOX_LOW  = 3'd0,
        REG_VIEW_BOX_HIGH = 3'd1,
        REG_NORMAL_A      = 3'd2,
        REG_NORMAL_B      = 3'd3,
        REG_NORMAL_C      = 3'd4,
        REG_NORMAL_D      = 3'd5,
        REG_OFFSETS_AB    = 3'd6,
        REG_OFFSETS_CD    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE = 2'd0,
        VERDICT_PARTIAL = 2'd1,
        VERDICT_INSIDE  = 2'd2
    } verdict_t;

endpackage

// ===== hdl/aabb_frustum_cull_test_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_core
// classifies one axis-aligned box per beat against a box-and-planes frustum
// ----------------------------------------------------------------------------
// One box beat enters per clock unless in_stall is raised; its verdict passes
// the stages input compare/corner select, multiply, plane sums and verdict
// register in order. The sustained rate is one box per cycle when out_stall is
// low: stage two holds all twenty-four normal-by-coordinate multipliers side
// by side, one per plane, corner and axis. Each stage loads whenever it is
// empty or the stage after it moves, so bubbles collapse and a stalled output
// only backs up as far as the first empty stage. Configuration registers feed
// the pipe directly and must be written only while no box is in flight.
module aabb_frustum_cull_test_core (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // configuration write port
    input  logic                                        cfg_we,
    input  logic [aabbfc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [aabbfc_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    // box input channel
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_x,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_y,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_z,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_x,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_y,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_z,
    // verdict output channel
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic [1:0]                                  verdict
);
    import aabbfc_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VIEW_BOX_BITS-1:0]   view_low_reg;
    logic [VIEW_BOX_BITS-1:0]   view_high_reg;
    logic [NORMAL_REG_BITS-1:0] normal_reg [PLANE_REGS];
    logic [OFFSET_REG_BITS-1:0] offsets_ab_reg;
    logic [OFFSET_REG_BITS-1:0] offsets_cd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_low_reg   <= '0;
            view_high_reg  <= '0;
            for (int p = 0; p < PLANE_REGS; p++)
            begin
                normal_reg[p] <= '0;
            end
            offsets_ab_reg <= '0;
            offsets_cd_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_VIEW_BOX_LOW:  view_low_reg   <= cfg_data[VIEW_BOX_BITS-1:0];
                REG_VIEW_BOX_HIGH: view_high_reg  <= cfg_data[VIEW_BOX_BITS-1:0];
                REG_NORMAL_A:      normal_reg[0]  <= cfg_data[NORMAL_REG_BITS-1:0];
                REG_NORMAL_B:      normal_reg[1]  <= cfg_data[NORMAL_REG_BITS-1:0];
                REG_NORMAL_C:      normal_reg[2]  <= cfg_data[NORMAL_REG_BITS-1:0];
                REG_NORMAL_D:      normal_reg[3]  <= cfg_data[NORMAL_REG_BITS-1:0];
                REG_OFFSETS_AB:    offsets_ab_reg <= cfg_data[OFFSET_REG_BITS-1:0];
                REG_OFFSETS_CD:    offsets_cd_reg <= cfg_data[OFFSET_REG_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // unpacked views of the frustum registers
    logic signed [NORMAL_BITS-1:0] normal_c [PLANE_REGS][AXES];
    logic signed [OFFSET_BITS-1:0] offset_c [PLANE_REGS];
    logic signed [COORD_BITS-1:0]  view_low_c  [AXES];
    logic signed [COORD_BITS-1:0]  view_high_c [AXES];

    always_comb
    begin
        for (int p = 0; p < PLANE_REGS; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                normal_c[p][a] = $signed(normal_reg[p][a*NORMAL_BITS +: NORMAL_BITS]);
            end
        end
        offset_c[0] = $signed(offsets_ab_reg[OFFSET_BITS-1:0]);
        offset_c[1] = $signed(offsets_ab_reg[2*OFFSET_BITS-1:OFFSET_BITS]);
        offset_c[2] = $signed(offsets_cd_reg[OFFSET_BITS-1:0]);
        offset_c[3] = $signed(offsets_cd_reg[2*OFFSET_BITS-1:OFFSET_BITS]);
        for (int a = 0; a < AXES; a++)
        begin
            view_low_c[a]  = $signed(view_low_reg[a*COORD_BITS +: COORD_BITS]);
            view_high_c[a] = $signed(view_high_reg[a*COORD_BITS +: COORD_BITS]);
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, out_valid_next;
    logic load1, load2, load3, load_out;

    assign load_out = !out_valid_reg || !out_stall;
    assign load3    = !v3_reg || load_out;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_stall = !load1;

    assign v1_next        = in_valid;
    assign v2_next        = v1_reg;
    assign v3_next        = v2_reg;
    assign out_valid_next = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= v1_next;
            end
            if (load2)
            begin
                v2_reg <= v2_next;
            end
            if (load3)
            begin
                v3_reg <= v3_next;
            end
            if (load_out)
            begin
                out_valid_reg <= out_valid_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: enclosing box test and positive / negative corner select
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] lo_c [AXES];
    logic signed [COORD_BITS-1:0] hi_c [AXES];
    logic                         box_out1_next;
    logic signed [COORD_BITS-1:0] pos1_next [ACTIVE_PLANES][AXES];
    logic signed [COORD_BITS-1:0] neg1_next [ACTIVE_PLANES][AXES];

    logic                         box_out1_reg;
    logic signed [COORD_BITS-1:0] pos1_reg [ACTIVE_PLANES][AXES];
    logic signed [COORD_BITS-1:0] neg1_reg [ACTIVE_PLANES][AXES];

    always_comb
    begin
        // INPUT_BITS equals COORD_BITS, so every input coordinate bit is kept
        lo_c[0] = $signed(low_x[COORD_BITS-1:0]);
        lo_c[1] = $signed(low_y[COORD_BITS-1:0]);
        lo_c[2] = $signed(low_z[COORD_BITS-1:0]);
        hi_c[0] = $signed(high_x[COORD_BITS-1:0]);
        hi_c[1] = $signed(high_y[COORD_BITS-1:0]);
        hi_c[2] = $signed(high_z[COORD_BITS-1:0]);

        box_out1_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if ((hi_c[a] < view_low_c[a]) || (lo_c[a] > view_high_c[a]))
            begin
                box_out1_next = 1'b1;
            end
        end

        // a non-negative normal component takes the max coordinate
        for (int p = 0; p < ACTIVE_PLANES; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (normal_c[p][a][NORMAL_BITS-1])
                begin
                    pos1_next[p][a] = lo_c[a];
                    neg1_next[p][a] = hi_c[a];
                end
                else
                begin
                    pos1_next[p][a] = hi_c[a];
                    neg1_next[p][a] = lo_c[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            box_out1_reg <= box_out1_next;
            pos1_reg     <= pos1_next;
            neg1_reg     <= neg1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: normal times corner, one multiplier per plane, corner, axis
    // ------------------------------------------------------------------
    logic                        box_out2_reg;
    logic signed [PROD_BITS-1:0] pos_prod_next [ACTIVE_PLANES][AXES];
    logic signed [PROD_BITS-1:0] neg_prod_next [ACTIVE_PLANES][AXES];
    logic signed [PROD_BITS-1:0] pos_prod_reg  [ACTIVE_PLANES][AXES];
    logic signed [PROD_BITS-1:0] neg_prod_reg  [ACTIVE_PLANES][AXES];

    always_comb
    begin
        for (int p = 0; p < ACTIVE_PLANES; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pos_prod_next[p][a] = PROD_BITS'(normal_c[p][a]) * PROD_BITS'(pos1_reg[p][a]);
                neg_prod_next[p][a] = PROD_BITS'(normal_c[p][a]) * PROD_BITS'(neg1_reg[p][a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            box_out2_reg <= box_out1_reg;
            pos_prod_reg <= pos_prod_next;
            neg_prod_reg <= neg_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: exact plane sums, keep only the sign
    // ------------------------------------------------------------------
    logic                        box_out3_reg;
    logic [ACTIVE_PLANES-1:0]    pos_behind_next;
    logic [ACTIVE_PLANES-1:0]    neg_behind_next;
    logic [ACTIVE_PLANES-1:0]    pos_behind_reg;
    logic [ACTIVE_PLANES-1:0]    neg_behind_reg;
    logic signed [EVAL_BITS-1:0] off_ext  [ACTIVE_PLANES];
    logic signed [EVAL_BITS-1:0] pos_eval [ACTIVE_PLANES];
    logic signed [EVAL_BITS-1:0] neg_eval [ACTIVE_PLANES];

    always_comb
    begin
        for (int p = 0; p < ACTIVE_PLANES; p++)
        begin
            // offset is q.20, products are q.23
            off_ext[p]  = EVAL_BITS'(offset_c[p]) <<< OFFSET_SHIFT;
            pos_eval[p] = off_ext[p];
            neg_eval[p] = off_ext[p];
            for (int a = 0; a < AXES; a++)
            begin
                pos_eval[p] = pos_eval[p] + EVAL_BITS'(pos_prod_reg[p][a]);
                neg_eval[p] = neg_eval[p] + EVAL_BITS'(neg_prod_reg[p][a]);
            end
            pos_behind_next[p] = pos_eval[p][EVAL_BITS-1];
            neg_behind_next[p] = neg_eval[p][EVAL_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            box_out3_reg   <= box_out2_reg;
            pos_behind_reg <= pos_behind_next;
            neg_behind_reg <= neg_behind_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: verdict register, planes resolved in order
    // ------------------------------------------------------------------
    verdict_t verdict_next;
    verdict_t verdict_reg;
    logic     done_c;

    always_comb
    begin
        verdict_next = VERDICT_INSIDE;
        done_c       = 1'b0;
        if (box_out3_reg)
        begin
            verdict_next = VERDICT_OUTSIDE;
            done_c       = 1'b1;
        end
        for (int p = 0; p < ACTIVE_PLANES; p++)
        begin
            if (!done_c)
            begin
                if (pos_behind_reg[p])
                begin
                    // furthest corner behind: whole box behind this plane
                    verdict_next = VERDICT_OUTSIDE;
                    done_c       = 1'b1;
                end
                else if (neg_behind_reg[p])
                begin
                    verdict_next = VERDICT_PARTIAL;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a full pipe behind a stalled output must push back on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input accepted while pipe full and output stalled");

    // a box that misses the enclosing box always comes out as outside
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && v3_reg && box_out3_reg) |=> (verdict_reg == VERDICT_OUTSIDE))
        else $error("enclosing box miss not reported as outside");

    // a held first stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !load2) |=> v1_reg)
        else $error("stage one beat lost while held");

    // a beat in stage three moving on always shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && v3_reg) |=> out_valid_reg)
        else $error("stage three beat dropped on its way out");

endmodule

// ===== tb/cull_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cull_verdict_checker
// watches the box and verdict channels of the cull core, predicts each
// verdict from a private copy of the frustum registers and compares in order
// ----------------------------------------------------------------------------
module cull_verdict_checker (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [aabbfc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [aabbfc_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                        in_valid,
    input  logic                                        in_stall,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_x,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_y,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    low_z,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_x,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_y,
    input  logic signed [aabbfc_pkg::INPUT_BITS-1:0]    high_z,
    input  logic                                        out_valid,
    input  logic                                        out_stall,
    input  logic [1:0]                                  verdict,
    output int                                          fail_count,
    output int                                          outstanding
);

    import aabbfc_pkg::*;

    typedef logic [AXES*COORD_BITS-1:0] point_t;

    // frustum register copy
    logic [VIEW_BOX_BITS-1:0]   view_low;
    logic [VIEW_BOX_BITS-1:0]   view_high;
    logic [NORMAL_REG_BITS-1:0] normal_regs [PLANE_REGS];
    logic [OFFSET_REG_BITS-1:0] offsets_ab;
    logic [OFFSET_REG_BITS-1:0] offsets_cd;

    verdict_t verdicts_due [$];

    // plane value at a point, exact, in Q.23
    function automatic longint plane_value(input int p, input point_t pt);
        logic signed [OFFSET_BITS-1:0] d;
        logic signed [NORMAL_BITS-1:0] n;
        logic signed [COORD_BITS-1:0]  c;
        longint                        sum;
        int                            a;
        if (p < 2)
            d = offsets_ab[(p & 1)*OFFSET_BITS +: OFFSET_BITS];
        else
            d = offsets_cd[(p & 1)*OFFSET_BITS +: OFFSET_BITS];
        sum = longint'(d) * (1 << OFFSET_SHIFT);
        for (a = 0; a < AXES; a++)
        begin
            n = normal_regs[p & 3][a*NORMAL_BITS +: NORMAL_BITS];
            c = pt[a*COORD_BITS +: COORD_BITS];
            sum += longint'(n) * longint'(c);
        end
        return sum;
    endfunction

    function automatic verdict_t classify_box(input point_t lo, input point_t hi);
        logic signed [COORD_BITS-1:0]  l;
        logic signed [COORD_BITS-1:0]  h;
        logic signed [COORD_BITS-1:0]  vl;
        logic signed [COORD_BITS-1:0]  vh;
        logic signed [NORMAL_BITS-1:0] n;
        point_t                        pos;
        point_t                        neg;
        verdict_t                      v;
        int                            a;
        int                            p;
        // enclosing box rejection first
        for (a = 0; a < AXES; a++)
        begin
            l  = lo[a*COORD_BITS +: COORD_BITS];
            h  = hi[a*COORD_BITS +: COORD_BITS];
            vl = view_low[a*COORD_BITS +: COORD_BITS];
            vh = view_high[a*COORD_BITS +: COORD_BITS];
            if (h < vl || l > vh)
                return VERDICT_OUTSIDE;
        end
        v = VERDICT_INSIDE;
        for (p = 0; p < ACTIVE_PLANES; p++)
        begin
            for (a = 0; a < AXES; a++)
            begin
                n = normal_regs[p][a*NORMAL_BITS +: NORMAL_BITS];
                pos[a*COORD_BITS +: COORD_BITS] = (n >= 0) ? hi[a*COORD_BITS +: COORD_BITS]
                                                           : lo[a*COORD_BITS +: COORD_BITS];
                neg[a*COORD_BITS +: COORD_BITS] = (n >= 0) ? lo[a*COORD_BITS +: COORD_BITS]
                                                           : hi[a*COORD_BITS +: COORD_BITS];
            end
            if (plane_value(p, pos) < 0)
                return VERDICT_OUTSIDE;
            if (plane_value(p, neg) < 0)
                v = VERDICT_PARTIAL;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t due;
        int       i;
        if (!rst_n)
        begin
            view_low   = '0;
            view_high  = '0;
            for (i = 0; i < PLANE_REGS; i++)
                normal_regs[i] = '0;
            offsets_ab  = '0;
            offsets_cd  = '0;
            fail_count  = 0;
            verdicts_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t unexpected verdict beat: expected none, actual %0d",
                             $time, verdict);
                    fail_count++;
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (verdict !== due)
                    begin
                        $display("%0t verdict mismatch: expected %0d, actual %0d",
                                 $time, due, verdict);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                verdicts_due.push_back(classify_box(
                    {low_z[COORD_BITS-1:0], low_y[COORD_BITS-1:0], low_x[COORD_BITS-1:0]},
                    {high_z[COORD_BITS-1:0], high_y[COORD_BITS-1:0],
                     high_x[COORD_BITS-1:0]}));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VIEW_BOX_LOW:  view_low       = cfg_data[VIEW_BOX_BITS-1:0];
                    REG_VIEW_BOX_HIGH: view_high      = cfg_data[VIEW_BOX_BITS-1:0];
                    REG_NORMAL_A:      normal_regs[0] = cfg_data[NORMAL_REG_BITS-1:0];
                    REG_NORMAL_B:      normal_regs[1] = cfg_data[NORMAL_REG_BITS-1:0];
                    REG_NORMAL_C:      normal_regs[2] = cfg_data[NORMAL_REG_BITS-1:0];
                    REG_NORMAL_D:      normal_regs[3] = cfg_data[NORMAL_REG_BITS-1:0];
                    REG_OFFSETS_AB:    offsets_ab     = cfg_data;
                    REG_OFFSETS_CD:    offsets_cd     = cfg_data;
                    default: ;
                endcase
            end
            outstanding = verdicts_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the aabb frustum cull test core
// ----------------------------------------------------------------------------
// Programs a series of frustum settings (reset values, a hand-built frustum,
// wide, random, extreme and fully random register contents) and streams
// boxes through the core with random idle bursts on both channels. A checker
// beside the core predicts every verdict and counts mismatches.
// ----------------------------------------------------------------------------
module tb;

    import aabbfc_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int COORD_MAX    = (1 << (INPUT_BITS-1)) - 1;
    localparam int COORD_MIN    = -(1 << (INPUT_BITS-1));
    localparam int PHASE_BEATS  = 100;
    localparam int PHASES       = 9;

    typedef logic [AXES*INPUT_BITS-1:0] corner_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // core inputs, all known from time zero
    logic                              cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]         cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]          cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic signed [INPUT_BITS-1:0]      low_x     = '0;
    logic signed [INPUT_BITS-1:0]      low_y     = '0;
    logic signed [INPUT_BITS-1:0]      low_z     = '0;
    logic signed [INPUT_BITS-1:0]      high_x    = '0;
    logic signed [INPUT_BITS-1:0]      high_y    = '0;
    logic signed [INPUT_BITS-1:0]      high_z    = '0;
    logic                              out_stall = 1'b0;

    // core outputs
    logic       in_stall;
    logic       out_valid;
    logic [1:0] verdict;

    // checker status
    int fail_count;
    int outstanding;

    // register image for the next frustum and the view box it decodes to
    logic [CFG_DATA_BITS-1:0] frustum_regs [8];
    int                       view_lo [AXES];
    int                       view_hi [AXES];

    // percent chance of an idle burst, shared by both channels
    int idle_pct = 0;
    int stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    aabb_frustum_cull_test_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .low_x     (low_x),
        .low_y     (low_y),
        .low_z     (low_z),
        .high_x    (high_x),
        .high_y    (high_y),
        .high_z    (high_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict)
    );

    cull_verdict_checker verdict_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .low_x       (low_x),
        .low_y       (low_y),
        .low_z       (low_z),
        .high_x      (high_x),
        .high_y      (high_y),
        .high_z      (high_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver backpressure: random stall bursts, each begun with chance idle_pct
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (int'($urandom_range(0, 99)) < idle_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    // hard stop in case the core hangs
    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic corner_t corner(input int x, input int y, input int z);
        return {z[INPUT_BITS-1:0], y[INPUT_BITS-1:0], x[INPUT_BITS-1:0]};
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [NORMAL_BITS-1:0] extreme_normal();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [OFFSET_BITS-1:0] extreme_offset();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // one box beat, held until the core takes it; an idle burst may go first
    task automatic send_box(input corner_t lo, input corner_t hi);
        if (int'($urandom_range(0, 99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        low_x    <= lo[0*INPUT_BITS +: INPUT_BITS];
        low_y    <= lo[1*INPUT_BITS +: INPUT_BITS];
        low_z    <= lo[2*INPUT_BITS +: INPUT_BITS];
        high_x   <= hi[0*INPUT_BITS +: INPUT_BITS];
        high_y   <= hi[1*INPUT_BITS +: INPUT_BITS];
        high_z   <= hi[2*INPUT_BITS +: INPUT_BITS];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // wait for every predicted verdict, then let the pipe empty out
    task automatic drain();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // write the whole register image while the core is idle
    task automatic program_frustum();
        int i;
        int a;
        for (i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data  <= frustum_regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        // remember the view box so that random boxes can aim at it
        for (a = 0; a < AXES; a++)
        begin
            view_lo[a] = int'($signed(frustum_regs[REG_VIEW_BOX_LOW][a*INPUT_BITS +: INPUT_BITS]));
            view_hi[a] = int'($signed(frustum_regs[REG_VIEW_BOX_HIGH][a*INPUT_BITS +: INPUT_BITS]));
        end
    endtask

    // view box registers; junk above the 60 used bits must be ignored
    task automatic set_view(input corner_t lo, input corner_t hi);
        frustum_regs[REG_VIEW_BOX_LOW]  = rand64();
        frustum_regs[REG_VIEW_BOX_HIGH] = rand64();
        frustum_regs[REG_VIEW_BOX_LOW][VIEW_BOX_BITS-1:0]  = lo;
        frustum_regs[REG_VIEW_BOX_HIGH][VIEW_BOX_BITS-1:0] = hi;
    endtask

    // four planes; in the normal mix some are switched off (zero normal,
    // non-negative offset) so that inside verdicts stay common
    task automatic random_planes(input bit extreme);
        logic [NORMAL_REG_BITS-1:0] nv;
        logic [OFFSET_BITS-1:0]     d [PLANE_REGS];
        bit                         off;
        int                         p;
        int                         a;
        for (p = 0; p < PLANE_REGS; p++)
        begin
            off = !extreme && ($urandom_range(0, 2) == 0);
            nv  = '0;
            for (a = 0; a < AXES; a++)
                nv[a*NORMAL_BITS +: NORMAL_BITS] = off ? 16'h0000
                    : (extreme ? extreme_normal() : NORMAL_BITS'($urandom()));
            if (extreme)
                d[p] = extreme_offset();
            else if (off || $urandom_range(0, 3) != 0)
                d[p] = $urandom_range(0, 32'h7FFF_FFFF);
            else
                d[p] = $urandom();
            frustum_regs[int'(REG_NORMAL_A) + p] = rand64();
            frustum_regs[int'(REG_NORMAL_A) + p][NORMAL_REG_BITS-1:0] = nv;
        end
        frustum_regs[REG_OFFSETS_AB] = {d[1], d[0]};
        frustum_regs[REG_OFFSETS_CD] = {d[3], d[2]};
    endtask

    // mostly well-formed boxes around the view box at many sizes, plus raw
    // bit patterns and deliberately inverted boxes
    task automatic random_box(output corner_t lo, output corner_t hi);
        int mode;
        int flip;
        int a;
        int c;
        int s;
        int sh;
        int half;
        int l [AXES];
        int h [AXES];
        mode = $urandom_range(0, 9);
        flip = $urandom_range(0, AXES-1);
        for (a = 0; a < AXES; a++)
        begin
            if (mode == 0)
            begin
                l[a] = $urandom();
                h[a] = $urandom();
            end
            else
            begin
                if (view_hi[a] >= view_lo[a] && $urandom_range(0, 3) != 0)
                    c = view_lo[a] + int'($urandom_range(0, view_hi[a] - view_lo[a]));
                else
                    c = int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
                sh   = $urandom_range(0, 4);
                s    = (sh == 4) ? COORD_MAX : (1 << (4 + 4*sh));
                half = $urandom_range(0, s);
                l[a] = clamp_coord(c - half);
                h[a] = clamp_coord(c + half);
                // inverted box on one axis: corners go in as given
                if (mode == 1 && a == flip)
                begin
                    c    = l[a];
                    l[a] = h[a];
                    h[a] = c;
                end
            end
        end
        lo = corner(l[0], l[1], l[2]);
        hi = corner(h[0], h[1], h[2]);
    endtask

    initial
    begin : stimulus
        corner_t lo;
        corner_t hi;
        int      ph;
        int      a;
        int      va;
        int      vb;
        int      vlo [AXES];
        int      vhi [AXES];

        view_lo = '{0, 0, 0};
        view_hi = '{0, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frustum: view box is the single point at the origin and every
        // plane is zero, so only boxes touching the origin are inside
        send_box(corner(0, 0, 0), corner(0, 0, 0));
        send_box(corner(-1, -1, -1), corner(1, 1, 1));
        send_box(corner(1, 1, 1), corner(5, 5, 5));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MIN, COORD_MIN, COORD_MIN));
        // inverted box
        send_box(corner(5, 5, 5), corner(-5, -5, -5));
        in_valid <= 1'b0;
        drain();

        // hand-built frustum over the whole coordinate range:
        //   plane a  x >= 0
        //   plane b  y <= 1.0
        //   plane c  zero normal, always passes
        //   plane d  x + y + z below about 2048, all components -1.0
        set_view(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        frustum_regs[REG_NORMAL_A]   = {16'hA5A5, 16'h0000, 16'h0000, 16'h7FFF};
        frustum_regs[REG_NORMAL_B]   = {16'hFFFF, 16'h0000, 16'h8000, 16'h0000};
        frustum_regs[REG_NORMAL_C]   = {16'h5A5A, 16'h0000, 16'h0000, 16'h0000};
        frustum_regs[REG_NORMAL_D]   = {16'h0000, 16'h8000, 16'h8000, 16'h8000};
        frustum_regs[REG_OFFSETS_AB] = {32'h0010_0000, 32'h0000_0000};
        frustum_regs[REG_OFFSETS_CD] = {32'h7FFF_FFFF, 32'h0000_0000};
        program_frustum();

        send_box(corner(100, 0, 0), corner(200, 100, 100));
        send_box(corner(-100, 0, 0), corner(100, 10, 10));
        send_box(corner(-300, 0, 0), corner(-100, 10, 10));
        send_box(corner(10, 300, 0), corner(20, 400, 0));
        send_box(corner(0, 0, 0), corner(COORD_MAX, 0, 0));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(COORD_MAX, COORD_MAX, COORD_MAX), corner(COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(corner(COORD_MIN, COORD_MIN, COORD_MIN), corner(COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(corner(200, 0, 0), corner(100, 0, 0));
        send_box(corner(0, 0, 0), corner(0, 0, 0));
        in_valid <= 1'b0;
        drain();

        // random phases, each under a fresh frustum
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 5)
                0:
                begin
                    // widest view box, ordinary planes
                    set_view(corner(COORD_MIN, COORD_MIN, COORD_MIN),
                             corner(COORD_MAX, COORD_MAX, COORD_MAX));
                    random_planes(1'b0);
                end
                1:
                begin
                    // extreme normals and offsets
                    set_view(corner(COORD_MIN, COORD_MIN, COORD_MIN),
                             corner(COORD_MAX, COORD_MAX, COORD_MAX));
                    random_planes(1'b1);
                end
                2, 3:
                begin
                    // random ordered view box, some axes sometimes flat; extreme planes when ph % 5 is 3
                    for (a = 0; a < AXES; a++)
                    begin
                        va = int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
                        vb = ($urandom_range(0, 5) == 0) ? va
                             : int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
                        vlo[a] = (va < vb) ? va : vb;
                        vhi[a] = (va < vb) ? vb : va;
                    end
                    set_view(corner(vlo[0], vlo[1], vlo[2]), corner(vhi[0], vhi[1], vhi[2]));
                    random_planes(ph % 5 == 3);
                end
                default:
                begin
                    // raw register contents, inverted view boxes included
                    for (a = 0; a < 8; a++)
                        frustum_regs[a] = rand64();
                end
            endcase
            program_frustum();

            // no idling at all in the last phase
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 35;
                default: idle_pct = 15;
            endcase
            if (ph == PHASES - 1)
                idle_pct = 0;

            repeat (PHASE_BEATS)
            begin
                random_box(lo, hi);
                send_box(lo, hi);
            end
            in_valid <= 1'b0;
            drain();
        end

        repeat (2*PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
